[hdl/osf_pkg.sv]
package osf_pkg;

    localparam int DATA_W = 32;
    localparam int FIELD_W = 11;
    localparam int DEFAULT_STACK_DEPTH = 1024;

    typedef enum logic [3:0] {
        OP_PUSH       = 4'd0,
        OP_POP        = 4'd1,
        OP_PEEK       = 4'd2,
        OP_READ_AT    = 4'd3,
        OP_GET_LOCAL  = 4'd4,
        OP_SET_LOCAL  = 4'd5,
        OP_RETURN     = 4'd6,
        OP_BUMP       = 4'd7,
        OP_SET_FP     = 4'd8,
        OP_GET_FP     = 4'd9,
        OP_SAVE_FP    = 4'd10,
        OP_RESTORE_FP = 4'd11,
        OP_REVERSE    = 4'd12
    } op_t;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_RANGE    = 2'd2;

endpackage

[hdl/osf_ram.sv]
module osf_ram #(
    parameter int STACK_DEPTH = osf_pkg::DEFAULT_STACK_DEPTH,
    parameter int ADDR_W = $clog2(STACK_DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [osf_pkg::DATA_W-1:0] wdata,
    input  logic                       re_a,
    input  logic [ADDR_W-1:0]          raddr_a,
    output logic [osf_pkg::DATA_W-1:0] q_a,
    input  logic                       re_b,
    input  logic [ADDR_W-1:0]          raddr_b,
    output logic [osf_pkg::DATA_W-1:0] q_b
);
    import osf_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports: q holds while the port is not enabled
    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            q_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            q_b <= mem[raddr_b];
        end
    end

endmodule

[hdl/operand_stack_with_frames.sv]
// Operand stack with frame pointer for a stack-machine core.
// Command channel: a beat is taken at a rising edge with start high, busy low
// and config_write low (operation, value, index, result_count). Every beat
// gives one result beat: done is high for exactly one cycle with read_value,
// frame_pointer_out, top_pointer_out and error. The receiver has no way to
// stall; results must be taken in the cycle that done is high.
// Config: config_write loads config_data (saturated to STACK_DEPTH) into the
// top and frame pointers. Write it only while the block is idle.
// Plain ops (push, pop, peek, read_at, locals, frame pointer ops, erroring
// return or reverse, reverse of fewer than two entries) pass through the s2
// stage register and then the done register. These issue one per cycle.
// Return walks the store through one RAM read port: it copies the results,
// each write following its read, then zeroes every vacated slot, then raises
// done. Reverse swaps pairs inward, reading each pair through the two read
// ports and writing it back through the one write port. Reset: pointers clear
// to zero, then a clearing pass writes zero to every entry, one per cycle,
// with busy high. Config writes are taken during the pass.
module operand_stack_with_frames #(
    parameter int STACK_DEPTH = osf_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [3:0]                        operation,
    input  logic signed [osf_pkg::DATA_W-1:0] value,
    input  logic [osf_pkg::FIELD_W-1:0]       index,
    input  logic [osf_pkg::FIELD_W-1:0]       result_count,
    input  logic                              config_write,
    input  logic [osf_pkg::FIELD_W-1:0]       config_data,
    output logic                              done,
    output logic signed [osf_pkg::DATA_W-1:0] read_value,
    output logic [osf_pkg::FIELD_W-1:0]       frame_pointer_out,
    output logic [osf_pkg::FIELD_W-1:0]       top_pointer_out,
    output logic [1:0]                        error
);
    import osf_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int PTR_MIN_W = $clog2(STACK_DEPTH + 1);
    // pointers hold 0..STACK_DEPTH and also the 11-bit counts of the fields
    localparam int PTR_W = (PTR_MIN_W > FIELD_W) ? PTR_MIN_W : FIELD_W;
    localparam logic [PTR_W:0] DEPTH_X = (PTR_W + 1)'(STACK_DEPTH);
    localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(STACK_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RET_COPY,
        ST_RET_CLR,
        ST_REV_RD,
        ST_REV_WL,
        ST_REV_WH
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  top_reg, top_next;
    logic [PTR_W-1:0]  fp_reg, fp_next;
    logic [PTR_W-1:0]  sfp_reg, sfp_next;
    logic [PTR_W-1:0]  cnt_reg, cnt_next;     // clear addr, return k, reverse low
    logic [PTR_W-1:0]  lim_reg, lim_next;     // return count, reverse high
    logic [PTR_W-1:0]  base_reg, base_next;
    logic [PTR_W-1:0]  newtop_reg, newtop_next;
    logic              pend_reg, pend_next;
    logic              pend_zero_reg, pend_zero_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_rd_reg, s2_rd_next;
    logic [1:0]        s2_err_reg, s2_err_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] rv_reg, rv_next;
    logic [PTR_W-1:0]  fpo_reg, fpo_next;
    logic [PTR_W-1:0]  tpo_reg, tpo_next;
    logic [1:0]        err_reg, err_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re_a, re_b;
    logic [ADDR_W-1:0] raddr_a, raddr_b;
    logic [DATA_W-1:0] q_a, q_b;

    logic [PTR_W:0]    idx_x, rn_x, fp_x, top_x, cfg_x;
    logic [PTR_W:0]    local_pos, ret_base, ret_top, ret_src;
    logic [PTR_W-1:0]  ret_dst, top_dec;

    osf_ram #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .q_a     (q_a),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .q_b     (q_b)
    );

    assign busy = (state_reg != ST_IDLE);

    assign idx_x     = (PTR_W + 1)'(index);
    assign rn_x      = (PTR_W + 1)'(result_count);
    assign fp_x      = {1'b0, fp_reg};
    assign top_x     = {1'b0, top_reg};
    assign cfg_x     = (PTR_W + 1)'(config_data);
    assign local_pos = fp_x + idx_x;
    assign ret_base  = fp_x - idx_x;
    assign ret_top   = ret_base + rn_x;
    assign ret_src   = fp_x + {1'b0, cnt_reg};
    assign ret_dst   = base_reg + cnt_reg;
    assign top_dec   = top_reg - PTR_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        fp_next        = fp_reg;
        sfp_next       = sfp_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        base_next      = base_reg;
        newtop_next    = newtop_reg;
        pend_next      = pend_reg;
        pend_zero_next = pend_zero_reg;
        pend_addr_next = pend_addr_reg;
        s2_valid_next  = 1'b0;
        s2_rd_next     = 1'b0;
        s2_err_next    = ERR_OK;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        re_a           = 1'b0;
        raddr_a        = '0;
        re_b           = 1'b0;
        raddr_b        = '0;

        // result stage of plain ops; pointers already hold post-op values
        done_next = s2_valid_reg;
        rv_next   = s2_rd_reg ? q_a : '0;
        fpo_next  = fp_reg;
        tpo_next  = top_reg;
        err_next  = s2_err_reg;

        if (config_write && (state_reg == ST_IDLE || state_reg == ST_CLEAR))
        begin
            if (cfg_x > DEPTH_X)
            begin
                top_next = DEPTH_X[PTR_W-1:0];
                fp_next  = DEPTH_X[PTR_W-1:0];
            end
            else
            begin
                top_next = cfg_x[PTR_W-1:0];
                fp_next  = cfg_x[PTR_W-1:0];
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg[ADDR_W-1:0];
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + PTR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (start && !config_write)
                begin
                    s2_valid_next = 1'b1;
                    case (op_t'(operation))
                        OP_PUSH:
                        begin
                            if (top_x >= DEPTH_X)
                            begin
                                s2_err_next = ERR_OVERFLOW;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = top_reg[ADDR_W-1:0];
                                wdata    = $unsigned(value);
                                top_next = top_reg + PTR_W'(1);
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (top_reg == '0)
                            begin
                                s2_err_next = ERR_RANGE;
                            end
                            else
                            begin
                                re_a       = 1'b1;
                                raddr_a    = top_dec[ADDR_W-1:0];
                                s2_rd_next = 1'b1;
                                if (op_t'(operation) == OP_POP)
                                begin
                                    top_next = top_dec;
                                end
                            end
                        end
                        OP_READ_AT:
                        begin
                            if (idx_x >= DEPTH_X)
                            begin
                                s2_err_next = ERR_RANGE;
                            end
                            else
                            begin
                                re_a       = 1'b1;
                                raddr_a    = idx_x[ADDR_W-1:0];
                                s2_rd_next = 1'b1;
                            end
                        end
                        OP_GET_LOCAL, OP_SET_LOCAL:
                        begin
                            if (local_pos >= DEPTH_X)
                            begin
                                s2_err_next = ERR_RANGE;
                            end
                            else if (op_t'(operation) == OP_GET_LOCAL)
                            begin
                                re_a       = 1'b1;
                                raddr_a    = local_pos[ADDR_W-1:0];
                                s2_rd_next = 1'b1;
                            end
                            else
                            begin
                                we    = 1'b1;
                                waddr = local_pos[ADDR_W-1:0];
                                wdata = $unsigned(value);
                            end
                        end
                        OP_RETURN:
                        begin
                            if (idx_x > fp_x)
                            begin
                                s2_err_next = ERR_RANGE;
                            end
                            else if (ret_top > DEPTH_X)
                            begin
                                s2_err_next = ERR_OVERFLOW;
                            end
                            else
                            begin
                                s2_valid_next = 1'b0;
                                base_next     = ret_base[PTR_W-1:0];
                                newtop_next   = ret_top[PTR_W-1:0];
                                lim_next      = rn_x[PTR_W-1:0];
                                cnt_next      = '0;
                                pend_next     = 1'b0;
                                state_next    = ST_RET_COPY;
                            end
                        end
                        OP_BUMP:
                        begin
                            fp_next = top_reg;
                        end
                        OP_SET_FP:
                        begin
                            if (idx_x > DEPTH_X)
                            begin
                                s2_err_next = ERR_RANGE;
                            end
                            else
                            begin
                                fp_next = idx_x[PTR_W-1:0];
                            end
                        end
                        OP_GET_FP:
                        begin
                            fp_next = fp_reg;
                        end
                        OP_SAVE_FP:
                        begin
                            sfp_next = fp_reg;
                        end
                        OP_RESTORE_FP:
                        begin
                            fp_next = sfp_reg;
                        end
                        OP_REVERSE:
                        begin
                            if (idx_x > top_x)
                            begin
                                s2_err_next = ERR_RANGE;
                            end
                            else if (index > FIELD_W'(1))
                            begin
                                // lo = top - n, hi = top - 1; swap inward
                                s2_valid_next = 1'b0;
                                cnt_next      = top_reg - idx_x[PTR_W-1:0];
                                lim_next      = top_dec;
                                state_next    = ST_REV_RD;
                            end
                        end
                        default:
                        begin
                            s2_err_next = ERR_OK;
                        end
                    endcase
                end
            end

            ST_RET_COPY:
            begin
                // the write comes in the cycle after its read; sources never get overwritten
                // before they are read since the destination sits at or below them
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = pend_addr_reg;
                    wdata = pend_zero_reg ? '0 : q_a;
                end
                if (cnt_reg < lim_reg)
                begin
                    if (ret_src < top_x)
                    begin
                        re_a           = 1'b1;
                        raddr_a        = ret_src[ADDR_W-1:0];
                        pend_zero_next = 1'b0;
                    end
                    else
                    begin
                        pend_zero_next = 1'b1;
                    end
                    pend_next      = 1'b1;
                    pend_addr_next = ret_dst[ADDR_W-1:0];
                    cnt_next       = cnt_reg + PTR_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    cnt_next   = newtop_reg;
                    state_next = ST_RET_CLR;
                end
            end

            ST_RET_CLR:
            begin
                if (cnt_reg < top_reg)
                begin
                    we       = 1'b1;
                    waddr    = cnt_reg[ADDR_W-1:0];
                    cnt_next = cnt_reg + PTR_W'(1);
                end
                else
                begin
                    top_next   = newtop_reg;
                    done_next  = 1'b1;
                    rv_next    = '0;
                    fpo_next   = fp_reg;
                    tpo_next   = newtop_reg;
                    err_next   = ERR_OK;
                    state_next = ST_IDLE;
                end
            end

            ST_REV_RD:
            begin
                re_a       = 1'b1;
                raddr_a    = cnt_reg[ADDR_W-1:0];
                re_b       = 1'b1;
                raddr_b    = lim_reg[ADDR_W-1:0];
                state_next = ST_REV_WL;
            end

            ST_REV_WL:
            begin
                we         = 1'b1;
                waddr      = cnt_reg[ADDR_W-1:0];
                wdata      = q_b;
                state_next = ST_REV_WH;
            end

            ST_REV_WH:
            begin
                we       = 1'b1;
                waddr    = lim_reg[ADDR_W-1:0];
                wdata    = q_a;
                cnt_next = cnt_reg + PTR_W'(1);
                lim_next = lim_reg - PTR_W'(1);
                if ((cnt_reg + PTR_W'(2)) < lim_reg)
                begin
                    re_a       = 1'b1;
                    raddr_a    = cnt_next[ADDR_W-1:0];
                    re_b       = 1'b1;
                    raddr_b    = lim_next[ADDR_W-1:0];
                    state_next = ST_REV_WL;
                end
                else
                begin
                    done_next  = 1'b1;
                    rv_next    = '0;
                    fpo_next   = fp_reg;
                    tpo_next   = top_reg;
                    err_next   = ERR_OK;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            top_reg       <= '0;
            fp_reg        <= '0;
            sfp_reg       <= '0;
            cnt_reg       <= '0;
            lim_reg       <= '0;
            base_reg      <= '0;
            newtop_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_zero_reg <= 1'b0;
            pend_addr_reg <= '0;
            s2_valid_reg  <= 1'b0;
            s2_rd_reg     <= 1'b0;
            s2_err_reg    <= ERR_OK;
            done_reg      <= 1'b0;
            rv_reg        <= '0;
            fpo_reg       <= '0;
            tpo_reg       <= '0;
            err_reg       <= ERR_OK;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            fp_reg        <= fp_next;
            sfp_reg       <= sfp_next;
            cnt_reg       <= cnt_next;
            lim_reg       <= lim_next;
            base_reg      <= base_next;
            newtop_reg    <= newtop_next;
            pend_reg      <= pend_next;
            pend_zero_reg <= pend_zero_next;
            pend_addr_reg <= pend_addr_next;
            s2_valid_reg  <= s2_valid_next;
            s2_rd_reg     <= s2_rd_next;
            s2_err_reg    <= s2_err_next;
            done_reg      <= done_next;
            rv_reg        <= rv_next;
            fpo_reg       <= fpo_next;
            tpo_reg       <= tpo_next;
            err_reg       <= err_next;
        end
    end

    assign done              = done_reg;
    assign read_value        = $signed(rv_reg);
    assign frame_pointer_out = fpo_reg[FIELD_W-1:0];
    assign top_pointer_out   = tpo_reg[FIELD_W-1:0];
    assign error             = err_reg;

`ifndef SYNTHESIS
    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, top_reg} <= DEPTH_X)
        else $error("top pointer beyond stack depth");

    a_fp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, fp_reg} <= DEPTH_X)
        else $error("frame pointer beyond stack depth");

    a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!done_reg && !s2_valid_reg))
        else $error("result during clearing pass");

    a_plain_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !config_write && op_t'(operation) != OP_RETURN
         && op_t'(operation) != OP_REVERSE) |-> ##2 done)
        else $error("plain op result missing two edges after accept");

    a_clear_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RET_CLR && we) |-> (cnt_reg >= newtop_reg))
        else $error("return clears a live result slot");
`endif

endmodule
